>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// house form: clk_i and rst_ni of the enclosing module
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> sv/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Types and constants of the max-product assignment engine
// ----------------------------------------------------------------------------
package mpa_pkg;

  // configuration
  localparam int unsigned MAX_SIZE_DEF = 16;
  localparam int unsigned SIZE_W       = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // payload widths
  localparam int unsigned IDX_W = 4;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned RES_W = 33;
  localparam logic [PCT_W-1:0] HUNDRED = 7'd100;
  localparam logic [RES_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  // scaling datapath: product split into a high and a low chunk
  localparam int unsigned PROD_W = 39;
  localparam int unsigned LO_W   = 20;
  localparam int unsigned HI_W   = PROD_W - LO_W;
  localparam int unsigned QH_W   = RES_W - LO_W;
  localparam int unsigned REM_W  = 7;
  localparam int unsigned NEW_W  = REM_W + LO_W;

  // exact reciprocal of 100 for values below 2^27
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;

  // tag that travels with each column beat through the scaler
  typedef struct packed {
    logic use_col;
    logic tail;
  } mpa_tag_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } mpa_state_e;

endpackage

>>> sv/mpa_ram.sv
// ----------------------------------------------------------------------------
// mpa_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module mpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mpa_scale.sv
// ----------------------------------------------------------------------------
// mpa_scale
// Four-stage pipeline computing floor(percent * value / 100)
// ----------------------------------------------------------------------------
module mpa_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mpa_pkg::mpa_tag_t                 tag_i,
  input  logic [mpa_pkg::PCT_W-1:0]         pct_i,
  input  logic [mpa_pkg::RES_W-1:0]         val_i,
  output mpa_pkg::mpa_tag_t                 tag_o,
  output logic [mpa_pkg::RES_W-1:0]         prod_o
);

  localparam int unsigned MUL_W = mpa_pkg::PCT_W + mpa_pkg::RES_W;
  localparam int unsigned PH_W  = mpa_pkg::HI_W + mpa_pkg::RECIP_W;
  localparam int unsigned PL_W  = mpa_pkg::NEW_W + mpa_pkg::RECIP_W;

  mpa_pkg::mpa_tag_t tag1_q, tag2_q, tag3_q, tag4_q;

  logic [MUL_W-1:0]           mul_w;
  logic [mpa_pkg::PROD_W-1:0] x_q;
  logic [PH_W-1:0]            ph_w;
  logic [mpa_pkg::QH_W-1:0]   qh2_q, qh3_q, qh4_q;
  logic [mpa_pkg::HI_W-1:0]   xh2_q;
  logic [mpa_pkg::LO_W-1:0]   xl2_q;
  logic [mpa_pkg::HI_W-1:0]   rem_w;
  logic [mpa_pkg::NEW_W-1:0]  new3_q;
  logic [PL_W-1:0]            pl_w;
  logic [mpa_pkg::LO_W-1:0]   ql4_q;

  // tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  // stage 1: raw product, at most 100 * 2^32
  assign mul_w = MUL_W'(pct_i) * MUL_W'(val_i);

  // stage 2: quotient of the high chunk by reciprocal
  assign ph_w = PH_W'(x_q[mpa_pkg::PROD_W-1:mpa_pkg::LO_W]) * PH_W'(mpa_pkg::RECIP_100);

  // stage 3: remainder of the high chunk, joined with the low chunk
  assign rem_w = xh2_q - mpa_pkg::HI_W'(qh2_q) * mpa_pkg::HI_W'(mpa_pkg::HUNDRED);

  // stage 4: quotient of the joined value
  assign pl_w = PL_W'(new3_q) * PL_W'(mpa_pkg::RECIP_100);

  always_ff @(posedge clk_i) begin
    x_q    <= mul_w[mpa_pkg::PROD_W-1:0];
    qh2_q  <= ph_w[mpa_pkg::RECIP_SHIFT +: mpa_pkg::QH_W];
    xh2_q  <= x_q[mpa_pkg::PROD_W-1:mpa_pkg::LO_W];
    xl2_q  <= x_q[mpa_pkg::LO_W-1:0];
    new3_q <= {rem_w[mpa_pkg::REM_W-1:0], xl2_q};
    qh3_q  <= qh2_q;
    ql4_q  <= pl_w[mpa_pkg::RECIP_SHIFT +: mpa_pkg::LO_W];
    qh4_q  <= qh3_q;
  end

  assign tag_o  = tag4_q;
  assign prod_o = {qh4_q, ql4_q};

endmodule

>>> sv/max_product_assignment_dp.sv
// ----------------------------------------------------------------------------
// max_product_assignment_dp
// Best-probability row/column assignment over a subset table in memory
// ----------------------------------------------------------------------------
// Matrix entries load one per cycle (start high, busy low) into the chance
// memory. An entry with last set loads and then starts the search: busy rises
// and the subset table is rebuilt from the full mask downward. Each mask walks
// all n columns through one read port of the subset memory and the scaling
// pipeline, then waits for the pipeline to drain before writing its entry, with
// n = min(size, MAX_SIZE). The result is shown for one cycle on
// best_product_o with out_valid_o and cannot be held off; a last entry with
// size zero answers 1.0 in the next cycle without going busy. The user writes
// size through the cfg channel only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_product_assignment_dp #(
  parameter int unsigned MAX_SIZE = mpa_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mpa_pkg::IDX_W-1:0]   row_i,
  input  logic [mpa_pkg::IDX_W-1:0]   col_i,
  input  logic [mpa_pkg::PCT_W-1:0]   percent_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mpa_pkg::SIZE_W-1:0]  cfg_size_i,
  output logic                        out_valid_o,
  output logic [mpa_pkg::RES_W-1:0]   best_product_o
);

  localparam int unsigned TD = MAX_SIZE * MAX_SIZE;
  localparam int unsigned TW = (TD > 1) ? $clog2(TD) : 1;
  localparam int unsigned MW = MAX_SIZE;
  localparam int unsigned SD = 1 << MAX_SIZE;
  localparam int unsigned JW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);

  mpa_pkg::mpa_state_e state_q, state_d;

  logic [mpa_pkg::SIZE_W-1:0] size_q;
  logic [MW-1:0]              m_q, m_d;
  logic [JW-1:0]              j_q, j_d;
  logic [NW-1:0]              n_q, n_d;
  logic [mpa_pkg::RES_W-1:0]  acc_q, acc_d;
  logic [mpa_pkg::RES_W-1:0]  res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  mpa_pkg::mpa_tag_t          issue_tag_q, issue_tag_d;

  logic                       accept_w;
  logic [NW-1:0]              n_eff_w;
  logic [MW:0]                full_ext_w;
  logic [MW-1:0]              full_w;
  logic [NW-1:0]              r_cnt;
  logic [MW-1:0]              bit_sel_w;
  logic                       tail_j_w;
  logic [mpa_pkg::PCT_W-1:0]  pct_sat_w;

  logic                       tab_we;
  logic [TW-1:0]              tab_waddr, tab_raddr;
  logic [mpa_pkg::PCT_W-1:0]  tab_rdata;
  logic                       sub_we;
  logic [MW-1:0]              sub_waddr, sub_raddr;
  logic [mpa_pkg::RES_W-1:0]  sub_wdata, sub_rdata;

  mpa_pkg::mpa_tag_t          out_tag;
  logic [mpa_pkg::RES_W-1:0]  prod;
  logic [mpa_pkg::RES_W-1:0]  final_w;

  assign accept_w    = start && !busy;
  assign busy        = (state_q != mpa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // active size, clamped to the table
  assign n_eff_w    = (32'(size_q) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_q);
  assign full_ext_w = ((MW + 1)'(1) << n_eff_w) - (MW + 1)'(1);
  assign full_w     = full_ext_w[MW-1:0];

  // rows already taken = columns set in the mask
  always_comb begin
    r_cnt = '0;
    for (int b = 0; b < MAX_SIZE; b++) begin
      r_cnt = r_cnt + NW'(m_q[b]);
    end
  end

  assign bit_sel_w = MW'(1) << j_q;
  assign tail_j_w  = ((32'(j_q) + 32'd1) == 32'(n_q));
  assign pct_sat_w = (percent_i > mpa_pkg::HUNDRED) ? mpa_pkg::HUNDRED : percent_i;

  // chance memory: written on load, read per column during the search
  assign tab_we    = accept_w && (32'(row_i) < MAX_SIZE) && (32'(col_i) < MAX_SIZE);
  assign tab_waddr = TW'(32'(row_i) * 32'(MAX_SIZE) + 32'(col_i));
  assign tab_raddr = TW'(32'(r_cnt) * 32'(MAX_SIZE) + 32'(j_q));
  assign sub_raddr = m_q | bit_sel_w;

  mpa_ram #(
    .WIDTH (mpa_pkg::PCT_W),
    .DEPTH (TD)
  ) u_chance_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (pct_sat_w),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  mpa_ram #(
    .WIDTH (mpa_pkg::RES_W),
    .DEPTH (SD)
  ) u_subset_ram (
    .clk_i   (clk_i),
    .we_i    (sub_we),
    .waddr_i (sub_waddr),
    .wdata_i (sub_wdata),
    .raddr_i (sub_raddr),
    .rdata_o (sub_rdata)
  );

  mpa_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (issue_tag_q),
    .pct_i  (tab_rdata),
    .val_i  (sub_rdata),
    .tag_o  (out_tag),
    .prod_o (prod)
  );

  // running best over the free columns of the current mask
  assign final_w = (out_tag.use_col && (prod > acc_q)) ? prod : acc_q;

  // sequencer: load, column walk, drain and write back
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    j_d         = j_q;
    n_d         = n_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_valid_d = 1'b0;
    issue_tag_d = '0;
    sub_we      = 1'b0;
    sub_waddr   = m_q;
    sub_wdata   = final_w;

    if (out_tag.tail) begin
      acc_d = '0;
    end else if (out_tag.use_col) begin
      acc_d = final_w;
    end

    unique case (state_q)
      mpa_pkg::ST_IDLE: begin
        if (accept_w && last_i) begin
          if (n_eff_w == '0) begin
            res_d       = mpa_pkg::ONE_Q32;
            out_valid_d = 1'b1;
          end else begin
            sub_we    = 1'b1;
            sub_waddr = full_w;
            sub_wdata = mpa_pkg::ONE_Q32;
            m_d       = full_w - MW'(1);
            j_d       = '0;
            n_d       = n_eff_w;
            acc_d     = '0;
            state_d   = mpa_pkg::ST_ISSUE;
          end
        end
      end
      mpa_pkg::ST_ISSUE: begin
        issue_tag_d.use_col = ~m_q[j_q];
        issue_tag_d.tail    = tail_j_w;
        if (tail_j_w) begin
          state_d = mpa_pkg::ST_WAIT;
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      mpa_pkg::ST_WAIT: begin
        if (out_tag.tail) begin
          sub_we = 1'b1;
          if (m_q == '0) begin
            res_d       = final_w;
            out_valid_d = 1'b1;
            state_d     = mpa_pkg::ST_IDLE;
          end else begin
            m_d     = m_q - MW'(1);
            j_d     = '0;
            state_d = mpa_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = mpa_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpa_pkg::ST_IDLE;
      size_q      <= mpa_pkg::SIZE_RESET;
      m_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      issue_tag_q <= '0;
    end else begin
      state_q     <= state_d;
      m_q         <= m_d;
      j_q         <= j_d;
      n_q         <= n_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      issue_tag_q <= issue_tag_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_size_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign best_product_o = res_q;

  // checks
  `ASSERT_STD(a_tail_in_wait, out_tag.tail |-> (state_q == mpa_pkg::ST_WAIT), "tail beat outside drain")
  `ASSERT_STD(a_wb_on_tail, (sub_we && state_q == mpa_pkg::ST_WAIT) |-> out_tag.tail, "early write back")
  `ASSERT_STD(a_issue_next, (state_q == mpa_pkg::ST_ISSUE) |=> (state_q == mpa_pkg::ST_ISSUE || state_q == mpa_pkg::ST_WAIT), "column walk left early")
  `ASSERT_STD(a_idle_quiet, (state_q == mpa_pkg::ST_IDLE) |-> !issue_tag_q.tail && !out_tag.tail, "beats in flight while idle")

endmodule

>>> tb/sv/mpa_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_search_checker
// Watches the max-product assignment engine, predicts and compares results
// ----------------------------------------------------------------------------
// Mirrors the chance memory and the size register from the beats it sees.
// On every accepted entry with last set, it rebuilds the subset table the
// same way the engine does and queues the expected best product. Each result
// strobe is checked against the oldest queued value.
// ----------------------------------------------------------------------------
module mpa_search_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [mpa_pkg::IDX_W-1:0]   row_i,
  input  logic [mpa_pkg::IDX_W-1:0]   col_i,
  input  logic [mpa_pkg::PCT_W-1:0]   percent_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [mpa_pkg::SIZE_W-1:0]  cfg_size_i,
  input  logic                        out_valid_o,
  input  logic [mpa_pkg::RES_W-1:0]   best_product_o,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o,
  output int unsigned                 searches_o
);

  localparam int unsigned MAX_N = mpa_pkg::MAX_SIZE_DEF;

  // mirrored engine state
  logic [mpa_pkg::PCT_W-1:0]  chance_mem [MAX_N*MAX_N];
  logic [mpa_pkg::RES_W-1:0]  subset_best_mem [1 << MAX_N];
  logic [mpa_pkg::SIZE_W-1:0] size_q;
  logic [mpa_pkg::RES_W-1:0]  expected_best_q [$];
  logic [mpa_pkg::RES_W-1:0]  want;

  // best product over all row-to-column assignments, masks walked downward
  function automatic logic [mpa_pkg::RES_W-1:0] max_assignment_product(
    input logic [mpa_pkg::SIZE_W-1:0] size_val
  );
    int unsigned n;
    int unsigned full;
    int unsigned taken;
    int unsigned j;
    int          m;
    logic [63:0] scaled;
    logic [63:0] best;
    n    = (size_val > MAX_N) ? MAX_N : int'(size_val);
    full = (1 << n) - 1;
    subset_best_mem[full] = mpa_pkg::ONE_Q32;
    for (m = int'(full) - 1; m >= 0; m--) begin
      taken = $countones(m);
      best  = '0;
      for (j = 0; j < n; j++) begin
        if (((m >> j) & 1) == 0) begin
          scaled = (64'(chance_mem[taken*MAX_N + j]) * 64'(subset_best_mem[m | (1 << j)]))
                   / 64'(mpa_pkg::HUNDRED);
          if (scaled > best) best = scaled;
        end
      end
      subset_best_mem[m] = best[mpa_pkg::RES_W-1:0];
    end
    return subset_best_mem[0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = mpa_pkg::SIZE_RESET;
      expected_best_q.delete();
      pending_o  = 0;
      errors_o   = 0;
      searches_o = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_o) begin
        if (expected_best_q.size() == 0) begin
          $error("best_product: result with nothing expected, actual %0d", best_product_o);
          errors_o++;
        end else begin
          want = expected_best_q.pop_front();
          searches_o++;
          if (best_product_o !== want) begin
            $error("best_product mismatch: expected %0d, actual %0d", want, best_product_o);
            errors_o++;
          end
        end
      end
      // accepted matrix entry, saturated to 100 percent, seen with the old size
      if (start && !busy) begin
        chance_mem[{row_i, col_i}] =
          (percent_i > mpa_pkg::HUNDRED) ? mpa_pkg::HUNDRED : percent_i;
        if (last_i) expected_best_q = {expected_best_q, max_assignment_product(size_q)};
      end
      // size register write
      if (cfg_valid_i && cfg_ready_o) size_q = cfg_size_i;
      pending_o = expected_best_q.size();
    end
  end

endmodule

>>> tb/sv/max_product_assignment_dp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_product_assignment_dp_tb
// Stimulus and verdict for the max-product assignment engine
// ----------------------------------------------------------------------------
// Loads matrices of success percentages at many sizes, starts searches with
// the last flag and lets the checker compare each best product. A directed
// opening covers the percent and index extremes, saturation, entries outside
// the active size and size zero; one search runs at the full size; the rest
// are random matrices, partial updates and stray writes with random gaps.
// ----------------------------------------------------------------------------
module max_product_assignment_dp_tb;

  localparam int unsigned ENTRY_TARGET = 1900;
  localparam int unsigned MAX_N        = mpa_pkg::MAX_SIZE_DEF;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [mpa_pkg::IDX_W-1:0]   row_i;
  logic [mpa_pkg::IDX_W-1:0]   col_i;
  logic [mpa_pkg::PCT_W-1:0]   percent_i;
  logic                        last_i;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [mpa_pkg::SIZE_W-1:0]  cfg_size_i;
  logic                        out_valid_o;
  logic [mpa_pkg::RES_W-1:0]   best_product_o;

  int unsigned pending;
  int unsigned errors;
  int unsigned searches;

  // stimulus bookkeeping
  bit                         entry_written [MAX_N*MAX_N];
  bit                         burst_mode;
  logic [mpa_pkg::SIZE_W-1:0] size_cur;
  int unsigned                entries_sent;
  int unsigned                size_writes;

  max_product_assignment_dp u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .row_i          (row_i),
    .col_i          (col_i),
    .percent_i      (percent_i),
    .last_i         (last_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_size_i     (cfg_size_i),
    .out_valid_o    (out_valid_o),
    .best_product_o (best_product_o)
  );

  mpa_search_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .row_i          (row_i),
    .col_i          (col_i),
    .percent_i      (percent_i),
    .last_i         (last_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_size_i     (cfg_size_i),
    .out_valid_o    (out_valid_o),
    .best_product_o (best_product_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .searches_o     (searches)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // percent mix: mostly likely pairings, some weak ones, edges and overflow
  function automatic logic [mpa_pkg::PCT_W-1:0] draw_percent(input bit hot);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (hot) return mpa_pkg::PCT_W'($urandom_range(85, 100));
    if (sel < 13) return mpa_pkg::PCT_W'($urandom_range(40, 100));
    if (sel < 16) return mpa_pkg::PCT_W'($urandom_range(0, 39));
    if (sel == 16) return mpa_pkg::HUNDRED;
    if (sel == 17) return '0;
    return mpa_pkg::PCT_W'($urandom_range(101, 127));
  endfunction

  // one matrix entry beat, held until the engine takes it
  task automatic send_entry(input logic [mpa_pkg::IDX_W-1:0] r,
                            input logic [mpa_pkg::IDX_W-1:0] c,
                            input logic [mpa_pkg::PCT_W-1:0] p, input logic l);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start     = 1'b1;
    row_i     = r;
    col_i     = c;
    percent_i = p;
    last_i    = l;
    do @(posedge clk_i); while (busy);
    entry_written[{r, c}] = 1'b1;
    entries_sent++;
  endtask

  // size write once the engine is idle and every result is in
  task automatic set_size(input logic [mpa_pkg::SIZE_W-1:0] v);
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8 + $urandom_range(0, 15)) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_size_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    size_cur    = v;
    size_writes++;
  endtask

  // n-by-n block in random order with stray writes mixed in, last on the end
  task automatic send_block(input int unsigned n, input bit full, input bit hot);
    int unsigned cells [MAX_N*MAX_N];
    int unsigned i;
    int unsigned pick;
    int unsigned tmp;
    int unsigned count;
    for (i = 0; i < n*n; i++) cells[i] = i;
    for (i = n*n - 1; i > 0; i--) begin
      pick        = $urandom_range(0, i);
      tmp         = cells[i];
      cells[i]    = cells[pick];
      cells[pick] = tmp;
    end
    count = full ? n*n : $urandom_range(1, n*n);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_entry(mpa_pkg::IDX_W'($urandom), mpa_pkg::IDX_W'($urandom),
                   draw_percent(1'b0), 1'b0);
      send_entry(mpa_pkg::IDX_W'(cells[i] / n), mpa_pkg::IDX_W'(cells[i] % n),
                 draw_percent(hot), i == count - 1);
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned sel;
    int unsigned kind;
    int unsigned r;
    int unsigned c;
    bit          cells_ready;
    bit          new_size;
    rst_ni       = 1'b0;
    start        = 1'b0;
    row_i        = '0;
    col_i        = '0;
    percent_i    = '0;
    last_i       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_size_i   = '0;
    burst_mode   = 1'b0;
    size_cur     = mpa_pkg::SIZE_RESET;
    entries_sent = 0;
    size_writes  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // single cell: full, zero, saturated and smallest nonzero chance
    set_size(mpa_pkg::SIZE_W'(1));
    send_entry('0, '0, mpa_pkg::HUNDRED, 1'b1);
    send_entry('0, '0, '0, 1'b1);
    send_entry('0, '0, mpa_pkg::PCT_W'(127), 1'b1);
    send_entry('0, '0, mpa_pkg::PCT_W'(101), 1'b1);
    send_entry('0, '0, mpa_pkg::PCT_W'(1), 1'b1);

    // two by two where the cross assignment wins, then writes outside the size
    burst_mode = 1'b1;
    set_size(mpa_pkg::SIZE_W'(2));
    send_entry(mpa_pkg::IDX_W'(0), mpa_pkg::IDX_W'(0), mpa_pkg::PCT_W'(50), 1'b0);
    send_entry(mpa_pkg::IDX_W'(0), mpa_pkg::IDX_W'(1), mpa_pkg::HUNDRED, 1'b0);
    send_entry(mpa_pkg::IDX_W'(1), mpa_pkg::IDX_W'(0), mpa_pkg::HUNDRED, 1'b0);
    send_entry(mpa_pkg::IDX_W'(1), mpa_pkg::IDX_W'(1), mpa_pkg::PCT_W'(50), 1'b1);
    send_entry(mpa_pkg::IDX_W'(15), mpa_pkg::IDX_W'(15), mpa_pkg::PCT_W'(77), 1'b0);
    send_entry(mpa_pkg::IDX_W'(15), mpa_pkg::IDX_W'(0), mpa_pkg::PCT_W'(64), 1'b0);
    send_entry(mpa_pkg::IDX_W'(0), mpa_pkg::IDX_W'(15), mpa_pkg::PCT_W'(127), 1'b0);
    send_entry(mpa_pkg::IDX_W'(1), mpa_pkg::IDX_W'(1), mpa_pkg::PCT_W'(99), 1'b1);

    // size zero answers the empty assignment, even from an outside entry
    burst_mode = 1'b0;
    set_size('0);
    send_entry(mpa_pkg::IDX_W'(15), mpa_pkg::IDX_W'(15), mpa_pkg::PCT_W'(1), 1'b1);

    // one search at the full size or above it
    set_size(mpa_pkg::SIZE_W'($urandom_range(MAX_N, 31)));
    send_block(MAX_N, 1'b1, 1'b1);

    // random matrices, partial updates and stray writes at small sizes
    new_size = 1'b1;
    while (entries_sent < ENTRY_TARGET) begin
      if (new_size || $urandom_range(0, 2) == 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) set_size('0);
        else if (sel == 1) set_size(mpa_pkg::SIZE_W'($urandom_range(8, 9)));
        else set_size(mpa_pkg::SIZE_W'($urandom_range(1, 7)));
        new_size = 1'b0;
      end
      n           = (size_cur > MAX_N) ? MAX_N : int'(size_cur);
      burst_mode  = ($urandom_range(0, 3) == 0);
      cells_ready = 1'b1;
      for (r = 0; r < n; r++)
        for (c = 0; c < n; c++)
          if (!entry_written[r*MAX_N + c]) cells_ready = 1'b0;
      kind = $urandom_range(0, 9);
      if (n == 0)
        send_entry(mpa_pkg::IDX_W'($urandom), mpa_pkg::IDX_W'($urandom),
                   draw_percent(1'b0), 1'b1);
      else if (!cells_ready || kind < 6)
        send_block(n, 1'b1, 1'b0);
      else if (kind < 9)
        send_block(n, 1'b0, 1'b0);
      else
        repeat ($urandom_range(2, 6))
          send_entry(mpa_pkg::IDX_W'($urandom), mpa_pkg::IDX_W'($urandom),
                     draw_percent(1'b0), 1'b0);
    end

    // drain
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d matrix entries and %0d size writes, sizes zero to full",
             entries_sent, size_writes);
    $display("checked %0d search results", searches);
    if (errors == 0 && pending == 0) begin
      $display("max_product_assignment_dp_tb: PASS");
    end else begin
      $display("max_product_assignment_dp_tb: FAIL");
    end
    $finish;
  end

  // run limit, well above one full-size search plus a size-nine search per entry
  initial begin
    #(150_000_000);
    $display("max_product_assignment_dp_tb: FAIL");
    $finish;
  end

endmodule

>>> max_product_assignment_dp.f
+incdir+sv
sv/mpa_pkg.sv
sv/mpa_ram.sv
sv/mpa_scale.sv
sv/max_product_assignment_dp.sv
tb/sv/mpa_search_checker.sv
tb/sv/max_product_assignment_dp_tb.sv
